/* sv/octave_gradient_noise_2d_macros.svh */
// Assertion macros for the octave gradient noise block.
// Used by the port checker; no other dependencies.
`ifndef OCTAVE_GRADIENT_NOISE_2D_MACROS_SVH
`define OCTAVE_GRADIENT_NOISE_2D_MACROS_SVH
// implication checked every clock, skipped during reset
`define OGN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// next-cycle implication
`define OGN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`endif

/* sv/ogn_pkg.sv */
// Shared constants, types and helpers for the octave gradient noise block.
// No dependencies.
package ogn_pkg;
  localparam int MaxOctaves = 8;
  localparam int TableSize  = 256;
  localparam int FracBits   = 16;
  localparam int OctW       = $clog2(MaxOctaves);
  localparam int TabW       = $clog2(TableSize);
  localparam int AddrW      = OctW + TabW;
  localparam int OutW       = 25;
  localparam logic [31:0] GradXFlags = 32'h46552222;
  localparam logic [31:0] GradYFlags = 32'h2222550A;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RDA   = 10'b0000000010,
    S_RDB   = 10'b0000000100,
    S_RDAA  = 10'b0000001000,
    S_RDAB  = 10'b0000010000,
    S_RDBA  = 10'b0000100000,
    S_RDBB  = 10'b0001000000,
    S_HASH  = 10'b0010000000,
    S_MATH  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  // hashed byte -> gradient dot product with (dx,dy); dx,dy signed 18 bits
  function automatic logic signed [18:0] grad_dot(input logic [7:0] hb,
      input logic signed [17:0] dx, input logic signed [17:0] dy);
    logic [4:0] h;
    logic [1:0] gx;
    logic [1:0] gy;
    logic signed [18:0] r;
    h  = {hb[3:0], 1'b0};
    gx = 2'(GradXFlags >> h);
    gy = 2'(GradYFlags >> h);
    r = '0;
    if (gx == 2'd0) r = r - 19'(dx);
    else if (gx == 2'd2) r = r + 19'(dx);
    if (gy == 2'd0) r = r - 19'(dy);
    else if (gy == 2'd2) r = r + 19'(dy);
    return r;
  endfunction
endpackage

/* sv/ogn_ram.sv */
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module ogn_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* sv/ogn_math.sv */
// Per-octave fade and lerp datapath, a multiplier-a-step sequencer.
// Depends on ogn_pkg.
module ogn_math import ogn_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [FracBits-1:0]      fx,
  input  logic [FracBits-1:0]      fy,
  input  logic signed [18:0]       gaa,
  input  logic signed [18:0]       gba,
  input  logic signed [18:0]       gab,
  input  logic signed [18:0]       gbb,
  output logic                     done,
  output logic signed [19:0]       result
);
  // steps: 0 p2x,1 p3x,2 ux,3 p2y,4 p3y,5 vy,6 c1,7 c2,8 final
  logic [3:0] step;
  logic busy;
  logic [FracBits:0] p2, p3, u, v;
  logic signed [19:0] c1, c2;
  logic [FracBits-1:0] f;
  logic [35:0] prod_u;
  logic signed [40:0] prod_s;
  logic [FracBits+4:0] q;
  logic signed [20:0] diff;
  logic signed [19:0] base;
  logic [FracBits:0] t;

  always_comb begin
    f = (step < 4'd3) ? fx : fy;
    q = 21'(6 * 21'(p2)) + 21'(10 << FracBits) - 21'(15 * 21'(f));
    prod_u = '0;
    case (step)
      4'd0, 4'd3: prod_u = 36'(f) * 36'(f);
      4'd1, 4'd4: prod_u = 36'(p2) * 36'(f);
      4'd2, 4'd5: prod_u = 36'(p3) * 36'(q);
      default: prod_u = '0;
    endcase
    base = (step == 4'd6) ? 20'(gaa) : (step == 4'd7) ? 20'(gab) : c1;
    diff = (step == 4'd6) ? 21'(gba) - 21'(gaa) :
           (step == 4'd7) ? 21'(gbb) - 21'(gab) : 21'(c2) - 21'(c1);
    t = (step == 4'd8) ? v : u;
    prod_s = 41'(diff) * $signed({24'd0, t});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 4'd1;
        if (step == 4'd8) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
    case (step)
      4'd0, 4'd3: p2 <= 17'(prod_u >> FracBits);
      4'd1, 4'd4: p3 <= 17'(prod_u >> FracBits);
      4'd2: u <= 17'(prod_u >> FracBits);
      4'd5: v <= 17'(prod_u >> FracBits);
      4'd6: c1 <= base + 20'(prod_s >>> FracBits);
      4'd7: c2 <= base + 20'(prod_s >>> FracBits);
      4'd8: result <= base + 20'(prod_s >>> FracBits);
      default: ;
    endcase
  end
endmodule

/* sv/octave_gradient_noise_2d.sv */
// Top level of the octave gradient noise block.
// Depends on ogn_pkg, ogn_ram and ogn_math.
//
// Usage:
//  - Input channel in_valid/in_stall carries opcode and its fields. A write
//    beat (opcode 0) stores one permutation byte; it makes no result. An
//    evaluate beat (opcode 1) returns one noise_sum beat.
//  - Output channel out_valid/out_stall. The result sits in an output
//    register; while it is stalled, no new item is taken.
//  - Configuration: octave_count_we/octave_count_wdata, write when idle.
//    0 acts as 1, values above 8 as 8.
//  - Sequencing: per octave, ten dependent reads of the 2048-byte table memory
//    go through its one read port (two cell, four corner and four rehash
//    lookups), then the fade and lerps run as nine multiplier steps. One item
//    is in flight at a time; the next is taken once the result beat leaves.
//  - Reset: synchronous rst clears control and sets octave_count to 1.
//    Table contents are undefined until written; no clearing pass.
module octave_gradient_noise_2d import ogn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  opcode,
  input  logic [2:0]            table_octave,
  input  logic [7:0]            table_index,
  input  logic [7:0]            table_value,
  input  logic signed [31:0]    coord_x,
  input  logic signed [31:0]    coord_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [OutW-1:0] noise_sum,
  input  logic                  octave_count_we,
  input  logic [3:0]            octave_count_wdata
);
  state_t state;
  logic [3:0] oct_cfg;
  logic [3:0] n_oct;
  logic [3:0] oct;
  logic signed [31:0] x_r, y_r;
  logic signed [31:0] xs, ys;
  logic [7:0] cx, cy;
  logic [7:0] pa, pb, haa, hab, hba, hbb;
  logic [7:0] raddr_lo;
  logic [7:0] rdata;
  logic [AddrW-1:0] raddr;
  logic we;
  logic signed [18:0] gaa, gba, gab, gbb;
  logic signed [17:0] dx0, dx1, dy0, dy1;
  logic m_start, m_done;
  logic signed [19:0] m_res;
  logic signed [27:0] sum;
  logic signed [27:0] sum_next;
  logic accept;
  logic [2:0] hstep;

  assign in_stall = (state != S_IDLE) || out_valid;
  assign accept = in_valid && !in_stall;
  assign we = accept && (opcode == OP_WRITE);

  // arithmetic shift is the floor shift for the octave
  assign xs = x_r >>> oct;
  assign ys = y_r >>> oct;
  assign cx = xs[FracBits+7:FracBits];
  assign cy = ys[FracBits+7:FracBits];
  assign dx0 = 18'($unsigned(xs[FracBits-1:0]));
  assign dy0 = 18'($unsigned(ys[FracBits-1:0]));
  assign dx1 = dx0 - 18'(1 << FracBits);
  assign dy1 = dy0 - 18'(1 << FracBits);

  always_comb begin
    case (state)
      S_RDA:  raddr_lo = cx;
      S_RDB:  raddr_lo = cx + 8'd1;
      S_RDAA: raddr_lo = pa + cy;
      S_RDAB: raddr_lo = pa + cy + 8'd1;
      S_RDBA: raddr_lo = pb + cy;
      S_RDBB: raddr_lo = pb + cy + 8'd1;
      S_HASH: begin
        // second-level lookups: each corner byte goes through the table again
        case (hstep)
          3'd1: raddr_lo = haa;
          3'd2: raddr_lo = hab;
          3'd3: raddr_lo = hba;
          default: raddr_lo = hbb;
        endcase
      end
      default: raddr_lo = haa;
    endcase
  end
  assign raddr = {oct[OctW-1:0], raddr_lo};

  ogn_ram #(.Width(8), .Depth(MaxOctaves * TableSize)) u_perm (
    .clk(clk), .we(we), .waddr({table_octave, table_index}),
    .wdata(table_value), .raddr(raddr), .rdata(rdata)
  );

  assign gaa = grad_dot(haa, dx0, dy0);
  assign gba = grad_dot(hba, dx1, dy0);
  assign gab = grad_dot(hab, dx0, dy1);
  assign gbb = grad_dot(hbb, dx1, dy1);

  ogn_math u_math (
    .clk(clk), .rst(rst), .start(m_start),
    .fx(xs[FracBits-1:0]), .fy(ys[FracBits-1:0]),
    .gaa(gaa), .gba(gba), .gab(gab), .gbb(gbb),
    .done(m_done), .result(m_res)
  );

  assign sum_next = sum + (28'(m_res) <<< oct);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      oct_cfg <= 4'd1;
      m_start <= 1'b0;
      hstep <= '0;
    end else begin
      m_start <= 1'b0;
      if (octave_count_we) oct_cfg <= octave_count_wdata;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (accept && opcode == OP_EVAL) begin
          x_r <= coord_x;
          y_r <= coord_y;
          oct <= '0;
          sum <= '0;
          n_oct <= (oct_cfg == 4'd0) ? 4'd1 :
                   (oct_cfg > 4'(MaxOctaves)) ? 4'(MaxOctaves) : oct_cfg;
          state <= S_RDA;
        end
        S_RDA:  state <= S_RDB;
        S_RDB: begin pa <= rdata; state <= S_RDAA; end
        S_RDAA: begin pb <= rdata; state <= S_RDAB; end
        S_RDAB: begin haa <= rdata; state <= S_RDBA; end
        S_RDBA: begin hab <= rdata; state <= S_RDBB; end
        S_RDBB: begin hba <= rdata; hstep <= '0; state <= S_HASH; end
        S_HASH: begin
          // hbb arrives; then rehash the four bytes through the table
          hstep <= hstep + 3'd1;
          case (hstep)
            3'd0: hbb <= rdata;
            3'd2: haa <= rdata;
            3'd3: hab <= rdata;
            3'd4: hba <= rdata;
            3'd5: begin hbb <= rdata; m_start <= 1'b1; state <= S_MATH; end
            default: ;
          endcase
        end
        S_MATH: if (m_done) begin
          if (oct + 4'd1 == n_oct) begin
            sum <= sum_next;
            state <= S_OUT;
          end else begin
            sum <= sum_next;
            oct <= oct + 4'd1;
            state <= S_RDA;
          end
        end
        S_OUT: begin
          noise_sum <= (sum > 28'sd16777215) ? 25'h0FFFFFF :
                       (sum < -28'sd16777216) ? 25'h1000000 : sum[OutW-1:0];
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* sv/ogn_checker.sv */
// Port-level checker for octave_gradient_noise_2d, bound to the top level.
// Depends on the assertion macro header.
`include "octave_gradient_noise_2d_macros.svh"
module ogn_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic opcode,
  input logic out_valid,
  input logic out_stall,
  input logic [24:0] noise_sum
);
  `OGN_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(noise_sum))
  `OGN_ASSERT_IMP(a_busy, out_valid, in_stall)
  `OGN_ASSERT_NXT(a_eval, in_valid && !in_stall && opcode, in_stall)
endmodule

bind octave_gradient_noise_2d ogn_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .opcode(opcode), .out_valid(out_valid), .out_stall(out_stall),
  .noise_sum(noise_sum)
);
